### rtl/core/bcrf_pkg.sv
// Package: types, constants and arithmetic helpers for the bracketed cubic root finder
package bcrf_pkg;

	localparam int unsigned DefMaxIterations = 64;
	localparam int unsigned DefFracBits = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned ItersW = 7;

	localparam logic [CfgIdxW-1:0] RegMethod = 3'd0;
	localparam logic [CfgIdxW-1:0] RegCubic = 3'd1;
	localparam logic [CfgIdxW-1:0] RegSquare = 3'd2;
	localparam logic [CfgIdxW-1:0] RegLinear = 3'd3;
	localparam logic [CfgIdxW-1:0] RegConstant = 3'd4;
	localparam logic [CfgIdxW-1:0] RegTolerance = 3'd5;

	localparam logic [1:0] StConverged = 2'd0;
	localparam logic [1:0] StNoSign = 2'd1;
	localparam logic [1:0] StExactZero = 2'd2;
	localparam logic [1:0] StCap = 2'd3;

	localparam logic signed [31:0] RstCubic = -32'sd196608;
	localparam logic signed [31:0] RstSquare = 32'sd327680;
	localparam logic signed [31:0] RstLinear = -32'sd65536;
	localparam logic signed [31:0] RstConstant = 32'sd458752;
	localparam logic [30:0] RstTolerance = 31'd66;

	typedef struct packed {
		logic signed [31:0] left_bound;
		logic signed [31:0] right_bound;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] root;
		logic [1:0] status;
		logic [ItersW-1:0] iterations_used;
	} out_beat_t;

	typedef struct packed {
		logic method_select;
		logic signed [31:0] coef_cubic;
		logic signed [31:0] coef_square;
		logic signed [31:0] coef_linear;
		logic signed [31:0] coef_constant;
		logic [30:0] tolerance;
	} cfg_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE = 4'd0,
		OP_LOAD = 4'd1,
		OP_EVAL_A = 4'd2,
		OP_EVAL_B = 4'd3,
		OP_MID = 4'd4,
		OP_DIV_START = 4'd5,
		OP_FALSI_DONE = 4'd6,
		OP_EVAL_C = 4'd7,
		OP_UPDATE = 4'd8
	} op_t;

	typedef struct packed {
		op_t op;
		logic [2:0] mstep;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic no_sign;
		logic den_zero;
		logic stop_zero;
		logic stop_conv;
	} stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		begin
			if (v > 66'sh0_7FFF_FFFF)
				r = 32'sh7FFF_FFFF;
			else if (v < -66'sh0_8000_0000)
				r = 32'sh8000_0000;
			else
				r = v[31:0];
			return r;
		end
	endfunction

	function automatic logic [1:0] sgn2(input logic signed [31:0] v);
		begin
			return {v[31], v != 32'sd0};
		end
	endfunction

	// 1 when both strict signs are equal and non-zero
	function automatic logic same_sign(input logic signed [31:0] p, input logic signed [31:0] q);
		begin
			return (p != 32'sd0) && (q != 32'sd0) && (p[31] == q[31]);
		end
	endfunction

endpackage

### rtl/core/bcrf_div.sv
// Sequential unsigned divider, one quotient bit per cycle
module bcrf_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] dividend,
	input logic [31:0] divisor,
	output logic busy,
	output logic [63:0] quotient
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [6:0] cnt_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], quo_q[63]};
	assign trial = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != 7'd0) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 7'd0);
	assign quotient = quo_q;
endmodule

### rtl/core/bcrf_datapath.sv
// Datapath: registers, shared fixed-point multiplier, adder and divider
module bcrf_datapath #(
	parameter int unsigned FRAC_BITS = bcrf_pkg::DefFracBits
) (
	input logic clk,
	input logic arst_n,
	input bcrf_pkg::cfg_t cfg,
	input bcrf_pkg::in_beat_t in_beat,
	input bcrf_pkg::cmd_t cmd,
	output bcrf_pkg::stat_t stat,
	output logic signed [31:0] root
);
	import bcrf_pkg::*;

	logic signed [31:0] a_q, b_q, fa_q, fb_q, c_q, fc_q, prev_q;
	logic signed [31:0] x_q, x2_q, x3_q;
	logic signed [65:0] acc_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic signed [31:0] fxp;
	logic signed [63:0] mp_q;
	logic signed [31:0] dsel;
	logic div_start, div_busy;
	logic [63:0] div_quo;
	logic signed [32:0] den_w, diff_w;
	logic signed [32:0] sum_w, half_w;
	logic [31:0] mag_den_q;
	logic neg_q;
	logic [63:0] q_cl;
	logic signed [35:0] qs;
	logic signed [32:0] err;
	logic [32:0] abs_err;
	logic signed [31:0] x_sel;

	// Multiplier operands per micro step of a cubic evaluation
	always_comb begin
		mul_a = x_q;
		mul_b = x_q;
		case (cmd.mstep)
			3'd1: begin mul_a = x_q; mul_b = x_q; end
			3'd2: begin mul_a = cfg.coef_linear; mul_b = x_q; end
			3'd3: begin mul_a = x2_q; mul_b = x_q; end
			3'd4: begin mul_a = cfg.coef_square; mul_b = x2_q; end
			3'd5: begin mul_a = cfg.coef_cubic; mul_b = x3_q; end
			default: begin mul_a = x_q; mul_b = x_q; end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Floor shift of the registered product, then saturate
	assign fxp = sat32($signed({{2{mp_q[63]}}, mp_q}) >>> FRAC_BITS);

	assign den_w = {fa_q[31], fa_q} - {fb_q[31], fb_q};
	assign diff_w = {a_q[31], a_q} - {b_q[31], b_q};
	// Sum of the two operands of the bisection: exact, divided toward zero
	assign sum_w = {a_q[31], a_q} + {b_q[31], b_q};
	assign half_w = sum_w + {32'd0, sum_w[32]};
	assign q_cl = (div_quo > 64'h4_0000_0000) ? 64'h4_0000_0000 : div_quo;
	assign qs = neg_q ? -$signed({1'b0, q_cl[34:0]}) : $signed({1'b0, q_cl[34:0]});
	assign err = {c_q[31], c_q} - {prev_q[31], prev_q};
	assign abs_err = err[32] ? 33'(-err) : 33'(err);
	assign dsel = fb_q;

	assign div_start = (cmd.op == OP_DIV_START);

	bcrf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(64'(mp_q)),
		.divisor(mag_den_q),
		.busy(div_busy),
		.quotient(div_quo)
	);

	always_comb begin
		case (cmd.op)
			OP_EVAL_A: x_sel = a_q;
			OP_EVAL_B: x_sel = b_q;
			default: x_sel = c_q;
		endcase
	end

	always_ff @(posedge clk) begin
		// product |fb|*|a-b| prepared for the divider
		if (cmd.op == OP_MID)
			mp_q <= $signed({32'd0, (fb_q[31] ? 32'(-fb_q) : 32'(fb_q))})
				* $signed({31'd0, (diff_w[32] ? 33'(-diff_w) : 33'(diff_w))});
		else
			mp_q <= prod;
		case (cmd.op)
			OP_LOAD: begin
				a_q <= in_beat.left_bound;
				b_q <= in_beat.right_bound;
				c_q <= '0;
				prev_q <= '0;
			end
			OP_EVAL_A, OP_EVAL_B, OP_EVAL_C: begin
				// step 0 latches x, 1..5 issue products, 2..6 collect them, 7 takes f
				if (cmd.mstep == 3'd0)
					x_q <= x_sel;
				if (cmd.mstep == 3'd2)
					x2_q <= fxp;
				if (cmd.mstep == 3'd3)
					acc_q <= 66'(cfg.coef_constant) + 66'(fxp);
				if (cmd.mstep == 3'd4)
					x3_q <= fxp;
				if (cmd.mstep == 3'd5 || cmd.mstep == 3'd6)
					acc_q <= acc_q + 66'(fxp);
				if (cmd.mstep == 3'd7) begin
					if (cmd.op == OP_EVAL_A) fa_q <= sat32(acc_q);
					if (cmd.op == OP_EVAL_B) fb_q <= sat32(acc_q);
					if (cmd.op == OP_EVAL_C) fc_q <= sat32(acc_q);
				end
			end
			OP_MID: begin
				if (cfg.method_select)
					c_q <= half_w[32:1];
				mag_den_q <= den_w[32] ? 32'(-den_w) : 32'(den_w);
				neg_q <= (fb_q[31] != diff_w[32]) != den_w[32];
			end
			OP_FALSI_DONE: begin
				if (mag_den_q == 32'd0)
					c_q <= b_q;
				else
					c_q <= sat32(66'(b_q) - 66'(qs));
			end
			OP_UPDATE: begin
				if (same_sign(fa_q, fc_q)) begin
					a_q <= c_q; fa_q <= fc_q;
				end else if (same_sign(fb_q, fc_q)) begin
					b_q <= c_q; fb_q <= fc_q;
				end
				prev_q <= c_q;
			end
			default: ;
		endcase
	end

	assign stat.div_busy = div_busy;
	assign stat.no_sign = same_sign(fa_q, fb_q);
	assign stat.den_zero = (dsel == fa_q);
	assign stat.stop_zero = !same_sign(fa_q, fc_q) && !same_sign(fb_q, fc_q);
	assign stat.stop_conv = (abs_err <= {2'b00, cfg.tolerance});
	assign root = c_q;
endmodule

### rtl/core/bcrf_ctrl.sv
// Controller: sequences evaluations, midpoint, divide and update steps
module bcrf_ctrl #(
	parameter int unsigned MAX_ITERATIONS = bcrf_pkg::DefMaxIterations
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input logic method_select,
	input bcrf_pkg::stat_t stat,
	output bcrf_pkg::cmd_t cmd,
	output logic [1:0] status,
	output logic [bcrf_pkg::ItersW-1:0] iters
);
	import bcrf_pkg::*;

	localparam int unsigned CntW = $clog2(MAX_ITERATIONS + 1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_EVA = 9'b000000010,
		S_EVB = 9'b000000100,
		S_MID = 9'b000001000,
		S_DIV = 9'b000010000,
		S_FIN = 9'b000100000,
		S_EVC = 9'b001000000,
		S_UPD = 9'b010000000,
		S_OUT = 9'b100000000
	} state_t;

	state_t state_q;
	logic [2:0] step_q;
	logic [CntW-1:0] cnt_q;
	logic [1:0] status_q;
	logic div_wait_q;

	always_comb begin
		cmd.op = OP_NONE;
		cmd.mstep = step_q;
		case (state_q)
			S_IDLE: cmd.op = (in_valid && !in_stall) ? OP_LOAD : OP_NONE;
			S_EVA: cmd.op = OP_EVAL_A;
			S_EVB: cmd.op = OP_EVAL_B;
			S_MID: cmd.op = OP_MID;
			S_DIV: cmd.op = div_wait_q ? OP_NONE : OP_DIV_START;
			S_FIN: cmd.op = OP_FALSI_DONE;
			S_EVC: cmd.op = OP_EVAL_C;
			S_UPD: cmd.op = OP_UPDATE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			cnt_q <= '0;
			status_q <= StConverged;
			div_wait_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVA;
						step_q <= '0;
						cnt_q <= '0;
					end
				end
				S_EVA, S_EVB, S_EVC: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						if (state_q == S_EVA) begin
							state_q <= S_EVB;
						end else if (state_q == S_EVC) begin
							state_q <= S_UPD;
						end else begin
							state_q <= S_MID;
						end
					end
				end
				S_MID: begin
					if (cnt_q == '0 && stat.no_sign) begin
						status_q <= StNoSign;
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= method_select ? S_EVC : S_DIV;
						step_q <= '0;
					end
				end
				S_DIV: begin
					if (!div_wait_q) begin
						div_wait_q <= 1'b1;
					end else if (!stat.div_busy) begin
						div_wait_q <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_EVC;
					step_q <= '0;
				end
				S_UPD: begin
					if (stat.stop_zero) begin
						status_q <= StExactZero;
						state_q <= S_OUT;
					end else if (stat.stop_conv) begin
						status_q <= StConverged;
						state_q <= S_OUT;
					end else if (cnt_q >= CntW'(MAX_ITERATIONS)) begin
						status_q <= StCap;
						state_q <= S_OUT;
					end else begin
						state_q <= S_MID;
					end
				end
				S_OUT: begin
					if (!out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = status_q;
	assign iters = (cnt_q > CntW'(127)) ? ItersW'(127) : ItersW'(cnt_q);
endmodule

### rtl/core/bracketed_cubic_root_finder.sv
// Top level of the bracketed cubic root finder
//  channel | direction | handshake          | beat
//  in      | to block  | in_valid/in_stall  | in_beat_t {left_bound, right_bound}
//  out     | from block| out_valid/out_stall| out_beat_t {root, status, iterations_used}
//  cfg     | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data
// One item at a time. Each cubic evaluation runs on the shared multiplier;
// a regula falsi step adds a pass through the 64-bit serial divider.
// arst_n clears control and restores register defaults. A stalled result holds
// the block; no new beat is taken until it leaves.
module bracketed_cubic_root_finder #(
	parameter int unsigned MAX_ITERATIONS = bcrf_pkg::DefMaxIterations,
	parameter int unsigned FRAC_BITS = bcrf_pkg::DefFracBits
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input bcrf_pkg::in_beat_t in_beat,
	output logic out_valid,
	input logic out_stall,
	output bcrf_pkg::out_beat_t out_beat,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bcrf_pkg::CfgIdxW-1:0] cfg_index,
	input logic [bcrf_pkg::CfgDataW-1:0] cfg_data
);
	import bcrf_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	stat_t stat;
	logic [1:0] status;
	logic [ItersW-1:0] iters;
	logic signed [31:0] root;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.method_select <= 1'b0;
			cfg_q.coef_cubic <= RstCubic;
			cfg_q.coef_square <= RstSquare;
			cfg_q.coef_linear <= RstLinear;
			cfg_q.coef_constant <= RstConstant;
			cfg_q.tolerance <= RstTolerance;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegMethod: cfg_q.method_select <= cfg_data[0];
				RegCubic: cfg_q.coef_cubic <= cfg_data;
				RegSquare: cfg_q.coef_square <= cfg_data;
				RegLinear: cfg_q.coef_linear <= cfg_data;
				RegConstant: cfg_q.coef_constant <= cfg_data;
				RegTolerance: cfg_q.tolerance <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	bcrf_ctrl #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.method_select(cfg_q.method_select),
		.stat(stat),
		.cmd(cmd),
		.status(status),
		.iters(iters)
	);

	bcrf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_beat(in_beat),
		.cmd(cmd),
		.stat(stat),
		.root(root)
	);

	assign out_beat.root = (status == StNoSign) ? 32'sd0 : root;
	assign out_beat.status = status;
	assign out_beat.iterations_used = iters;
endmodule

### rtl/core/bcrf_checker.sv
// Port checker for the bracketed cubic root finder, with its bind
module bcrf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input bcrf_pkg::out_beat_t out_beat
);
	import bcrf_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_beat))
		else $error("result beat dropped under stall");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	a_nosign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.status == StNoSign |-> out_beat.iterations_used == '0)
		else $error("no sign change with steps");

	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.status != StNoSign |-> out_beat.iterations_used != '0)
		else $error("result without steps");
endmodule

bind bracketed_cubic_root_finder bcrf_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_beat(out_beat)
);
